/* rtl/jdc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package jdc_pkg;

  localparam int unsigned NUM_STAGES = 6;

  localparam logic [22:0] JD_BASE  = 23'd1721119;
  localparam logic [22:0] JD_FIRST = 23'd2361222;
  localparam logic [22:0] JD_LAST  = 23'd4643365;

  typedef enum logic {
    MODE_TO_NUMBER = 1'b0,
    MODE_TO_DATE   = 1'b1
  } mode_e;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef struct packed {
    mode_e       mode;
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [12:0] in_year;
    logic [22:0] in_day_number;
  } req_t;

  typedef struct packed {
    logic [22:0] out_day_number;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [12:0] out_year;
    logic        valid_res;
  } rsp_t;

  // days in a month, leap day handled separately
  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // (153 * m + 2) / 5 for a march-based month index
  function automatic logic [8:0] month_offset(input logic [3:0] month_idx);
    logic [8:0] ofs;
    case (month_idx)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd31;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd92;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd184;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd245;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

`default_nettype wire

/* rtl/jdc_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface jdc_req_if import jdc_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/jdc_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface jdc_rsp_if import jdc_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/jdc_date2num.sv */
`timescale 1ns / 1ps
`default_nettype none

module jdc_date2num import jdc_pkg::*; (
  input  logic        clk_i,
  input  stage_en_t   en_i,
  input  logic        active_i,
  input  logic [4:0]  day_i,
  input  logic [3:0]  month_i,
  input  logic [12:0] year_i,
  output logic [22:0] day_number_o,
  output logic        ok_o
);

  localparam logic [25:0] Recip100 = 26'd5243;

  // stage 1
  logic        early, base_ok, fits, feb29;
  logic [12:0] y_adj;
  logic [3:0]  m_adj;
  logic [25:0] c_prod, cy_prod;

  logic [4:0]  day1_q;
  logic [3:0]  madj1_q;
  logic [12:0] yadj1_q, year1_q;
  logic [6:0]  c1_q, cy1_q;
  logic        base_ok1_q, fits1_q, feb29_1_q;

  always_comb begin
    early = (year_i < 13'd1752) ||
            (year_i == 13'd1752 &&
             (month_i < 4'd9 || (month_i == 4'd9 && day_i < 5'd14)));
    base_ok = active_i && !early && day_i != 5'd0 && month_i != 4'd0 &&
              month_i <= 4'd12;
    fits  = day_i <= month_len(month_i);
    feb29 = day_i == 5'd29 && month_i == 4'd2;
    if (month_i > 4'd2) begin
      y_adj = year_i;
      m_adj = month_i - 4'd3;
    end else begin
      y_adj = year_i - 13'd1;
      m_adj = month_i + 4'd9;
    end
    c_prod  = 26'(y_adj) * Recip100;
    cy_prod = 26'(year_i) * Recip100;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      day1_q     <= day_i;
      madj1_q    <= m_adj;
      yadj1_q    <= y_adj;
      year1_q    <= year_i;
      c1_q       <= c_prod[25:19];
      cy1_q      <= cy_prod[25:19];
      base_ok1_q <= base_ok;
      fits1_q    <= fits;
      feb29_1_q  <= feb29;
    end
  end

  // stage 2: century split, leap year, century term
  logic [12:0] c_hund, cy_hund, r_full;
  logic        leap, ok2;
  logic [24:0] tc_prod;

  logic [4:0]  day2_q;
  logic [3:0]  madj2_q;
  logic [6:0]  r2_q;
  logic [22:0] tc2_q;
  logic        ok2_q;

  always_comb begin
    c_hund  = 13'(c1_q) * 13'd100;
    cy_hund = 13'(cy1_q) * 13'd100;
    r_full  = yadj1_q - c_hund;
    leap    = year1_q[1:0] == 2'd0 && (year1_q != cy_hund || cy1_q[1:0] == 2'd0);
    ok2     = base_ok1_q && (fits1_q || (feb29_1_q && leap));
    tc_prod = 25'(c1_q) * 25'd146097;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      day2_q  <= day1_q;
      madj2_q <= madj1_q;
      r2_q    <= r_full[6:0];
      tc2_q   <= tc_prod[24:2];
      ok2_q   <= ok2;
    end
  end

  // stage 3: year term and partial sum
  logic [17:0] ty_prod;
  logic [22:0] partial;

  logic [22:0] partial3_q;
  logic [15:0] ty3_q;
  logic        ok3_q;

  always_comb begin
    ty_prod = 18'(r2_q) * 18'd1461;
    partial = JD_BASE + 23'(day2_q) + tc2_q + 23'(month_offset(madj2_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      partial3_q <= partial;
      ty3_q      <= ty_prod[17:2];
      ok3_q      <= ok2_q;
    end
  end

  // stage 4: final sum, then two alignment stages
  logic [22:0] num4_q, num5_q, num6_q;
  logic        ok4_q, ok5_q, ok6_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      num4_q <= ok3_q ? (partial3_q + 23'(ty3_q)) : 23'd0;
      ok4_q  <= ok3_q;
    end
    if (en_i[4]) begin
      num5_q <= num4_q;
      ok5_q  <= ok4_q;
    end
    if (en_i[5]) begin
      num6_q <= num5_q;
      ok6_q  <= ok5_q;
    end
  end

  assign day_number_o = num6_q;
  assign ok_o         = ok6_q;

endmodule

`default_nettype wire

/* rtl/jdc_num2date.sv */
`timescale 1ns / 1ps
`default_nettype none

module jdc_num2date import jdc_pkg::*; (
  input  logic        clk_i,
  input  stage_en_t   en_i,
  input  logic        active_i,
  input  logic [22:0] day_number_i,
  output logic [4:0]  day_o,
  output logic [3:0]  month_o,
  output logic [12:0] year_o,
  output logic        ok_o
);

  localparam logic [24:0] TOffset  = 25'd6884477;
  localparam logic [24:0] CycleLen = 25'd146097;
  localparam logic [17:0] QuadLen  = 18'd1461;

  // stage 1: shifted count and century estimate
  logic        in_span;
  logic [24:0] t_full;
  logic [30:0] qe_prod;

  logic [23:0] t1_q;
  logic [6:0]  qe1_q;
  logic        ok1_q;

  always_comb begin
    in_span = active_i && day_number_i >= JD_FIRST && day_number_i <= JD_LAST;
    t_full  = {day_number_i, 2'b00} - TOffset;
    qe_prod = 31'(t_full[23:0]) * 31'd114;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      t1_q  <= t_full[23:0];
      qe1_q <= qe_prod[30:24];
      ok1_q <= in_span;
    end
  end

  // stage 2: century correction
  logic [24:0] rem_full, rem;
  logic [6:0]  c;

  logic [6:0]  c2_q;
  logic [17:0] t3_2_q;
  logic        ok2_q;

  always_comb begin
    rem_full = 25'(t1_q) - 25'(qe1_q) * CycleLen;
    if (rem_full >= CycleLen) begin
      c   = qe1_q + 7'd1;
      rem = rem_full - CycleLen;
    end else begin
      c   = qe1_q;
      rem = rem_full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      c2_q   <= c;
      t3_2_q <= {rem[17:2], 2'b11};
      ok2_q  <= ok1_q;
    end
  end

  // stage 3: year-in-century estimate
  logic [24:0] yy_prod;

  logic [17:0] t3_3_q;
  logic [6:0]  yye3_q;
  logic [12:0] c100_3_q;
  logic        ok3_q;

  assign yy_prod = 25'(t3_2_q) * 25'd179;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      t3_3_q   <= t3_2_q;
      yye3_q   <= yy_prod[24:18];
      c100_3_q <= 13'(c2_q) * 13'd100;
      ok3_q    <= ok2_q;
    end
  end

  // stage 4: year correction, day of year
  logic [17:0] dd2_full, dd2;
  logic [6:0]  yy;
  logic [11:0] dd3_sum;
  logic [8:0]  dd3;
  logic [10:0] t4;

  logic [10:0] t4_4_q;
  logic [12:0] year4_q;
  logic        ok4_q;

  always_comb begin
    dd2_full = t3_3_q - 18'(yye3_q) * QuadLen;
    if (dd2_full >= QuadLen) begin
      yy  = yye3_q + 7'd1;
      dd2 = dd2_full - QuadLen;
    end else begin
      yy  = yye3_q;
      dd2 = dd2_full;
    end
    dd3_sum = 12'(dd2[10:0]) + 12'd4;
    dd3     = dd3_sum[10:2];
    t4      = 11'({dd3, 2'b00}) + 11'(dd3) - 11'd3;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      t4_4_q  <= t4;
      year4_q <= c100_3_q + 13'(yy);
      ok4_q   <= ok3_q;
    end
  end

  // stage 5: month index by threshold compare
  logic [3:0]  mm;
  logic [10:0] dd4_full;

  logic [7:0]  dd4_5_q;
  logic [3:0]  mm5_q;
  logic [12:0] year5_q;
  logic        ok5_q;

  always_comb begin
    mm = 4'd0;
    for (int k = 1; k <= 11; k++) begin
      if (t4_4_q >= 11'(153 * k)) begin
        mm = mm + 4'd1;
      end
    end
    dd4_full = t4_4_q - 11'(mm) * 11'd153;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      dd4_5_q <= dd4_full[7:0];
      mm5_q   <= mm;
      year5_q <= year4_q;
      ok5_q   <= ok4_q;
    end
  end

  // stage 6: day of month, march-based month back to calendar
  logic [15:0] day_prod;
  logic        wrap;

  logic [4:0]  day6_q;
  logic [3:0]  month6_q;
  logic [12:0] year6_q;
  logic        ok6_q;

  always_comb begin
    day_prod = (16'(dd4_5_q) + 16'd5) * 16'd205;
    wrap     = mm5_q >= 4'd10;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      ok6_q <= ok5_q;
      if (ok5_q) begin
        day6_q   <= day_prod[14:10];
        month6_q <= wrap ? (mm5_q - 4'd9) : (mm5_q + 4'd3);
        year6_q  <= year5_q + 13'(wrap);
      end else begin
        day6_q   <= 5'd0;
        month6_q <= 4'd0;
        year6_q  <= 13'd0;
      end
    end
  end

  assign day_o   = day6_q;
  assign month_o = month6_q;
  assign year_o  = year6_q;
  assign ok_o    = ok6_q;

endmodule

`default_nettype wire

/* rtl/julian_day_converter_core.sv */
// Julian day number converter, Gregorian calendar.
// Request channel req_i: mode selects date to day number (in_day, in_month,
// in_year) or day number to date (in_day_number). A request is taken on a
// clock edge where valid and ready are both high.
// Response channel rsp_o: one response per request, in request order. The
// fields of the other mode are zero; valid_res is low for an unsupported date
// or a day number outside 14 Sep 1752 .. 31 Dec 8000, with the result zeroed.
// The six-stage pipeline takes one request per cycle while the receiver keeps
// ready high, and does the reciprocal divides with constant-coefficient
// multipliers.
// Each stage carries a valid bit and has its own enable, so empty stages
// close up. While the receiver holds ready low the response stays put and
// requests keep entering until all six stages hold data; then ready drops.
// Reset (rst_ni low, asynchronous) clears all stage valid bits: the
// response channel goes idle and ready is high once reset is released.
`timescale 1ns / 1ps
`default_nettype none

module julian_day_converter_core import jdc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  jdc_req_if.sink   req_i,
  jdc_rsp_if.source rsp_o
);

  stage_en_t   en;
  stage_en_t   v_q, v_d;
  logic [22:0] num;
  logic        num_ok, date_ok;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [12:0] year;

  always_comb begin
    en[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || rsp_o.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = {v_q[NUM_STAGES-2:0], req_i.valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  jdc_date2num u_date2num (
    .clk_i        (clk_i),
    .en_i         (en),
    .active_i     (req_i.data.mode == MODE_TO_NUMBER),
    .day_i        (req_i.data.in_day),
    .month_i      (req_i.data.in_month),
    .year_i       (req_i.data.in_year),
    .day_number_o (num),
    .ok_o         (num_ok)
  );

  jdc_num2date u_num2date (
    .clk_i        (clk_i),
    .en_i         (en),
    .active_i     (req_i.data.mode == MODE_TO_DATE),
    .day_number_i (req_i.data.in_day_number),
    .day_o        (day),
    .month_o      (month),
    .year_o       (year),
    .ok_o         (date_ok)
  );

  assign req_i.ready = en[0];
  assign rsp_o.valid = v_q[NUM_STAGES-1];

  always_comb begin
    rsp_o.data.out_day_number = num;
    rsp_o.data.out_day        = day;
    rsp_o.data.out_month      = month;
    rsp_o.data.out_year       = year;
    rsp_o.data.valid_res      = num_ok | date_ok;
  end

endmodule

`default_nettype wire

/* rtl/jdc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module jdc_checker import jdc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);

  // a stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("response changed while stalled");

  // an open output slot always lets a request in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_i || rsp_ready_i |-> req_ready_i)
    else $error("request blocked with room in the pipeline");

  // a rejected request gives an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_data_i.valid_res |->
      rsp_data_i.out_day_number == 23'd0 && rsp_data_i.out_day == 5'd0 &&
      rsp_data_i.out_month == 4'd0 && rsp_data_i.out_year == 13'd0)
    else $error("nonzero result on invalid response");

  // only one direction of conversion shows up in a response
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.out_day_number != 23'd0 |->
      rsp_data_i.out_day == 5'd0 && rsp_data_i.out_month == 4'd0 &&
      rsp_data_i.out_year == 13'd0)
    else $error("both conversion results present");

endmodule

bind julian_day_converter_core jdc_checker u_jdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

`default_nettype wire
